### src/plc_pkg.sv
`timescale 1ns / 1ps

package plc_pkg;

  localparam int unsigned PALETTE_ENTRIES_DEF = 1024;

  // input field widths
  localparam int unsigned ADDR_W  = 11;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ALPHA_W = 2;
  localparam int unsigned PEN_W   = 4;
  localparam int unsigned IDX_W   = ALPHA_W + 2 * PEN_W;
  localparam int unsigned CHAN_W  = 3;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned WORD_W  = 4 * CHAN_W;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  // item in flight between the memory read and the output register
  typedef struct packed {
    logic              valid;
    logic              kind;
    logic [IDX_W-1:0]  index;
    logic              wr_low;
    logic              wr_high;
    logic [BYTE_W-1:0] wr_byte;
  } stage_t;

endpackage

### src/palette_ram_layer_compositor.sv
`timescale 1ns / 1ps
// From input transfer to the earliest result transfer an item passes the memory read,
// then the output register.
// Throughput: one item per cycle while m_axis_tready is not held low; the banks take one write and one read per cycle.
// Reset: synchronous, active high. After reset a clearing pass zeroes all PALETTE_ENTRIES
// entries of both banks, one entry per cycle, while s_axis_tready is held low.
module palette_ram_layer_compositor #(
  parameter int unsigned PALETTE_ENTRIES = plc_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // palette_address[10:0], write_byte[18:11], alpha_pen[20:19],
  // sprite_pen[24:21], playfield_pen[28:25], zero fill
  input  logic [plc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                           s_axis_tuser,   // action
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // color_index[9:0], red[17:10], green[25:18], blue[33:26], zero fill
  output logic [plc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tuser    // result_kind
);
  import plc_pkg::*;

  localparam int unsigned EIDX_W = $clog2(PALETTE_ENTRIES);

  // input unpacking
  logic [ADDR_W-1:0]  in_addr;
  logic [BYTE_W-1:0]  in_byte;
  logic [ALPHA_W-1:0] in_alpha;
  logic [PEN_W-1:0]   in_sprite;
  logic [PEN_W-1:0]   in_play;

  assign in_addr   = s_axis_tdata[ADDR_W-1:0];
  assign in_byte   = s_axis_tdata[ADDR_W +: BYTE_W];
  assign in_alpha  = s_axis_tdata[ADDR_W+BYTE_W +: ALPHA_W];
  assign in_sprite = s_axis_tdata[ADDR_W+BYTE_W+ALPHA_W +: PEN_W];
  assign in_play   = s_axis_tdata[ADDR_W+BYTE_W+ALPHA_W+PEN_W +: PEN_W];

  // clearing pass after reset
  logic              clearing;
  logic [EIDX_W-1:0] clear_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + 1'b1;
      if (clear_addr == EIDX_W'(PALETTE_ENTRIES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // pipeline control
  stage_t s1;
  logic   out_valid;
  logic   s1_move;
  logic   accept;

  assign s1_move       = s1.valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !clearing && (!s1.valid || s1_move);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // entry selected by the incoming item
  logic              is_write;
  logic [EIDX_W-1:0] entry;
  logic              high_bank;

  assign is_write  = (s_axis_tuser == KIND_WRITE);
  assign high_bank = in_addr[EIDX_W];
  assign entry     = is_write ? in_addr[EIDX_W-1:0]
                              : EIDX_W'({in_alpha, in_sprite, in_play});

  // bank ports: clearing writes zeros to both banks
  logic              we_low;
  logic              we_high;
  logic [EIDX_W-1:0] waddr;
  logic [BYTE_W-1:0] wdata;
  logic [BYTE_W-1:0] rd_low;
  logic [BYTE_W-1:0] rd_high;

  assign we_low  = clearing || (accept && is_write && !high_bank);
  assign we_high = clearing || (accept && is_write && high_bank);
  assign waddr   = clearing ? clear_addr : entry;
  assign wdata   = clearing ? '0 : in_byte;

  plc_ram #(.DEPTH(PALETTE_ENTRIES)) u_low (
    .clk   (clk),
    .we    (we_low),
    .waddr (waddr),
    .wdata (wdata),
    .re    (accept),
    .raddr (entry),
    .rdata (rd_low)
  );

  plc_ram #(.DEPTH(PALETTE_ENTRIES)) u_high (
    .clk   (clk),
    .we    (we_high),
    .waddr (waddr),
    .wdata (wdata),
    .re    (accept),
    .raddr (entry),
    .rdata (rd_high)
  );

  // stage 1 sits alongside the registered read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (accept) begin
      s1.valid <= 1'b1;
    end else if (s1_move) begin
      s1.valid <= 1'b0;
    end
    if (accept) begin
      s1.kind    <= s_axis_tuser;
      s1.index   <= IDX_W'(entry);
      s1.wr_low  <= is_write && !high_bank;
      s1.wr_high <= is_write && high_bank;
      s1.wr_byte <= in_byte;
    end
  end

  // reads are read-first, so the byte just written is forwarded here
  logic [BYTE_W-1:0] lo_byte;
  logic [BYTE_W-1:0] hi_byte;
  logic [WORD_W-1:0] word;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;

  assign lo_byte = s1.wr_low  ? s1.wr_byte : rd_low;
  assign hi_byte = s1.wr_high ? s1.wr_byte : rd_high;
  assign word    = {hi_byte[WORD_W-BYTE_W-1:0], lo_byte};

  plc_rgb u_rgb (
    .word  (word),
    .red   (red),
    .green (green),
    .blue  (blue)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      m_axis_tuser <= s1.kind;
      m_axis_tdata <= OUT_DATA_W'({blue, green, red, s1.index});
    end
  end

  assign m_axis_tvalid = out_valid;

endmodule

### src/plc_ram.sv
`timescale 1ns / 1ps

module plc_ram #(
  parameter int unsigned DEPTH = plc_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [plc_pkg::BYTE_W-1:0] wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [plc_pkg::BYTE_W-1:0] rdata
);
  import plc_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  // read-first: a read at the write address returns the old byte
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/plc_rgb.sv
`timescale 1ns / 1ps

module plc_rgb (
  input  logic [plc_pkg::WORD_W-1:0]  word,
  output logic [plc_pkg::COLOR_W-1:0] red,
  output logic [plc_pkg::COLOR_W-1:0] green,
  output logic [plc_pkg::COLOR_W-1:0] blue
);
  import plc_pkg::*;

  // 5 * channel * intensity; the product of two 3-bit values fits 6 bits
  function automatic logic [COLOR_W-1:0] scale(input logic [CHAN_W-1:0] c,
                                               input logic [CHAN_W-1:0] i);
    logic [2*CHAN_W-1:0] p;
    logic [COLOR_W-1:0]  pw;
    p  = c * i;
    pw = COLOR_W'(p);
    return (pw << 2) + pw;
  endfunction

  logic [CHAN_W-1:0] inten;

  assign inten = word[3*CHAN_W +: CHAN_W];
  assign red   = scale(word[2*CHAN_W +: CHAN_W], inten);
  assign green = scale(word[CHAN_W +: CHAN_W], inten);
  assign blue  = scale(word[0 +: CHAN_W], inten);

endmodule
